[design/aaq_pkg.sv]
// Shared types, widths and constants for the axis-angle to quaternion converter.
// No dependencies; every other design file imports this package.
package aaq_pkg;

    localparam int AW      = 16;  // axis / angle field width
    localparam int SW      = 32;  // sum of squares width
    localparam int LW      = 24;  // axis length width, Q.8
    localparam int RW      = 27;  // square root partial remainder width
    localparam int CW      = 34;  // CORDIC datapath width, Q2.30 plus guard bits
    localparam int PW      = 50;  // axis times sine product width
    localparam int QW      = 32;  // quotient magnitude width
    localparam int DW      = 58;  // divider remainder width
    localparam int NLANE   = 3;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [CW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [CW-1:0] Q14_POS     = 34'sd16384;
    localparam logic signed [CW-1:0] Q14_NEG     = -34'sd16384;
    localparam logic signed [CW-1:0] Q14_RND     = 34'sd32768;
    localparam logic signed [AW-1:0] Q14_ONE     = 16'sd16384;

    // one request as it crosses from the front end to the back end
    typedef struct packed {
        logic signed [AW-1:0] ax;
        logic signed [AW-1:0] ay;
        logic signed [AW-1:0] az;
        logic signed [CW-1:0] h;
        logic                 neg;
        logic [LW-1:0]        len8;
        logic                 degen;
    } aaq_item_t;

    // truncated Q2.30 arctangent of 2^-i
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        case (i)
            0:       return 34'sh3243F6A8;
            1:       return 34'sh1DAC6705;
            2:       return 34'sh0FADBAFC;
            3:       return 34'sh07F56EA6;
            4:       return 34'sh03FEAB76;
            5:       return 34'sh01FFD55B;
            6:       return 34'sh00FFFAAA;
            7:       return 34'sh007FFF55;
            8:       return 34'sh003FFFEA;
            9:       return 34'sh001FFFFD;
            10:      return 34'sh000FFFFF;
            11:      return 34'sh0007FFFF;
            12:      return 34'sh0003FFFF;
            13:      return 34'sh0001FFFF;
            14:      return 34'sh0000FFFF;
            15:      return 34'sh00007FFF;
            16:      return 34'sh00003FFF;
            17:      return 34'sh00001FFF;
            18:      return 34'sh00000FFF;
            19:      return 34'sh000007FF;
            20:      return 34'sh000003FF;
            21:      return 34'sh000001FF;
            22:      return 34'sh000000FF;
            23:      return 34'sh0000007F;
            default: return '0;
        endcase
    endfunction

    // round Q2.30 to Q1.14 and clip to +/- one
    function automatic logic signed [AW-1:0] to_q14(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] r;
        t = v + Q14_RND;
        r = t >>> 16;
        if (r > Q14_POS)
            r = Q14_POS;
        if (r < Q14_NEG)
            r = Q14_NEG;
        return r[AW-1:0];
    endfunction

endpackage

[design/aaq_front.sv]
// Front end: input register, squares, half-angle reduction, pipelined square root.
// Flags short axes against the configured minimum. Depends on aaq_pkg.
module aaq_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      push,
    input  logic signed [15:0]        axis_x,
    input  logic signed [15:0]        axis_y,
    input  logic signed [15:0]        axis_z,
    input  logic signed [15:0]        angle,
    input  logic [15:0]               min_len,
    output logic                      out_valid,
    output aaq_pkg::aaq_item_t        out_item
);
    import aaq_pkg::*;

    // stage A: input register
    logic                 a_valid_reg;
    logic signed [AW-1:0] a_ax_reg, a_ay_reg, a_az_reg, a_ang_reg;

    // stage B: squares and reduced half angle
    logic                 b_valid_reg;
    logic [SW-2:0]        b_sqx_reg, b_sqy_reg, b_sqz_reg;
    aaq_item_t            b_item_reg;

    // square root pipeline, index 0 holds the sum
    logic                 s_valid_reg [0:LW];
    logic [SW-1:0]        s_sum_reg   [0:LW];
    logic [RW-1:0]        s_rem_reg   [0:LW];
    logic [LW-1:0]        s_root_reg  [0:LW];
    aaq_item_t            s_item_reg  [0:LW];

    logic signed [2*AW-1:0] sqx_full, sqy_full, sqz_full;
    logic signed [CW-1:0]   h_raw;
    aaq_item_t              b_item_next;
    logic [LW-1:0]          len_final;

    assign sqx_full = a_ax_reg * a_ax_reg;
    assign sqy_full = a_ay_reg * a_ay_reg;
    assign sqz_full = a_az_reg * a_az_reg;
    assign h_raw    = $signed({a_ang_reg[AW-1], a_ang_reg, 17'b0});

    // fold the half angle into [-pi/2, pi/2]
    always_comb
    begin
        b_item_next     = '0;
        b_item_next.ax  = a_ax_reg;
        b_item_next.ay  = a_ay_reg;
        b_item_next.az  = a_az_reg;
        b_item_next.h   = h_raw;
        b_item_next.neg = 1'b0;
        if (h_raw > Q30_HALF_PI)
        begin
            b_item_next.h   = h_raw - Q30_PI;
            b_item_next.neg = 1'b1;
        end
        else if (h_raw < -Q30_HALF_PI)
        begin
            b_item_next.h   = h_raw + Q30_PI;
            b_item_next.neg = 1'b1;
        end
    end

    // control for stages A and B
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= push;
            b_valid_reg <= a_valid_reg;
        end
    end

    // payload for stages A and B
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ax_reg   <= axis_x;
            a_ay_reg   <= axis_y;
            a_az_reg   <= axis_z;
            a_ang_reg  <= angle;
            b_sqx_reg  <= sqx_full[SW-2:0];
            b_sqy_reg  <= sqy_full[SW-2:0];
            b_sqz_reg  <= sqz_full[SW-2:0];
            b_item_reg <= b_item_next;
        end
    end

    // sum of squares enters the root pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg[0] <= 1'b0;
        else if (adv)
            s_valid_reg[0] <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_sum_reg[0]  <= SW'(b_sqx_reg) + SW'(b_sqy_reg) + SW'(b_sqz_reg);
            s_rem_reg[0]  <= '0;
            s_root_reg[0] <= '0;
            s_item_reg[0] <= b_item_reg;
        end
    end

    // one root bit per stage, radicand is sum * 2^16
    for (genvar k = 1; k <= LW; k++)
    begin : g_sqrt
        localparam int BI = 2 * (LW - k);
        logic [2*LW-1:0] rad;
        logic [RW-1:0]   rem_sh, trial;
        logic            take;

        assign rad    = {s_sum_reg[k-1], 16'b0};
        assign rem_sh = {s_rem_reg[k-1][RW-3:0], rad[BI+1 -: 2]};
        assign trial  = {1'b0, s_root_reg[k-1], 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_valid_reg[k] <= 1'b0;
            else if (adv)
                s_valid_reg[k] <= s_valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_sum_reg[k]  <= s_sum_reg[k-1];
                s_item_reg[k] <= s_item_reg[k-1];
                s_rem_reg[k]  <= take ? rem_sh - trial : rem_sh;
                s_root_reg[k] <= {s_root_reg[k-1][LW-2:0], take};
            end
        end
    end

    // length and short-axis flag
    assign len_final = s_root_reg[LW];
    always_comb
    begin
        out_item       = s_item_reg[LW];
        out_item.len8  = len_final;
        out_item.degen = (len_final == '0) || (len_final < {min_len, 8'b0});
    end
    assign out_valid = s_valid_reg[LW];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(a_valid_reg) && $stable(s_valid_reg[LW]))
        else $error("front pipeline moved while stalled");

endmodule

[design/aaq_fifo.sv]
// Short request queue between front end and back end.
// Four entries of aaq_item_t; depends on aaq_pkg.
module aaq_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  aaq_pkg::aaq_item_t wr_data,
    input  logic               rd_en,
    output aaq_pkg::aaq_item_t rd_data,
    output logic               empty,
    output logic               full
);
    import aaq_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTRW  = $clog2(DEPTH);

    aaq_item_t       mem_reg [0:DEPTH-1];
    logic [PTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTRW:0]   count_reg;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (PTRW+1)'(DEPTH));
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full && !rd_en))
        else $error("queue written while full");
    a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && empty))
        else $error("queue read while empty");

endmodule

[design/aaq_back.sv]
// Back end: CORDIC sine/cosine, axis times sine, pipelined division by the length,
// rounding to Q1.14 and the result register. Depends on aaq_pkg.
module aaq_back #(
    parameter int SINCOS_ITERATIONS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  aaq_pkg::aaq_item_t   in_item,
    output logic                 in_pop,
    input  logic                 out_pop,
    output logic                 out_empty,
    output logic signed [15:0]   quat_x,
    output logic signed [15:0]   quat_y,
    output logic signed [15:0]   quat_z,
    output logic signed [15:0]   quat_w,
    output logic                 degenerate_axis
);
    import aaq_pkg::*;

    localparam int NI = (SINCOS_ITERATIONS < ATAN_ENTRIES) ? SINCOS_ITERATIONS : ATAN_ENTRIES;

    logic adv;
    logic out_valid_reg;

    // CORDIC pipeline, index 0 is the loaded request
    logic                 c_valid_reg [0:NI];
    logic signed [CW-1:0] c_x_reg     [0:NI];
    logic signed [CW-1:0] c_y_reg     [0:NI];
    logic signed [CW-1:0] c_z_reg     [0:NI];
    aaq_item_t            c_item_reg  [0:NI];

    // product stage
    logic                 m_valid_reg;
    logic signed [PW-1:0] m_prod_reg [0:NLANE-1];
    logic signed [CW-1:0] m_x_reg;
    logic [LW-1:0]        m_len_reg;
    logic                 m_degen_reg;

    // divider pipeline
    logic                 d_valid_reg [0:QW];
    logic signed [CW-1:0] d_x_reg     [0:QW];
    logic [LW-1:0]        d_len_reg   [0:QW];
    logic                 d_degen_reg [0:QW];
    logic [DW-1:0]        d_rem_reg   [0:NLANE-1][0:QW];
    logic [QW-1:0]        d_q_reg     [0:NLANE-1][0:QW];
    logic                 d_sgn_reg   [0:NLANE-1][0:QW];

    // result register
    logic signed [AW-1:0] o_q_reg [0:NLANE-1];
    logic signed [AW-1:0] o_w_reg;
    logic                 o_degen_reg;
    logic signed [AW-1:0] lane_q [0:NLANE-1];

    logic signed [CW-1:0] last_x, last_y, yn, xn;
    logic signed [AW-1:0] lane_ax [0:NLANE-1];

    // whole back end moves when the result slot is free or being taken
    assign adv       = !out_valid_reg || out_pop;
    assign in_pop    = adv && in_valid;
    assign out_empty = !out_valid_reg;

    // load a request into the CORDIC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg[0] <= 1'b0;
        else if (adv)
            c_valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_x_reg[0]    <= CORDIC_GAIN;
            c_y_reg[0]    <= '0;
            c_z_reg[0]    <= in_item.h;
            c_item_reg[0] <= in_item;
        end
    end

    // one CORDIC rotation per stage
    for (genvar k = 1; k <= NI; k++)
    begin : g_cordic
        localparam int I = k - 1;
        logic signed [CW-1:0] dx, dy, at;

        assign dx = c_y_reg[k-1] >>> I;
        assign dy = c_x_reg[k-1] >>> I;
        assign at = atan_q30(I);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                c_valid_reg[k] <= 1'b0;
            else if (adv)
                c_valid_reg[k] <= c_valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                c_item_reg[k] <= c_item_reg[k-1];
                if (!c_z_reg[k-1][CW-1])
                begin
                    c_x_reg[k] <= c_x_reg[k-1] - dx;
                    c_y_reg[k] <= c_y_reg[k-1] + dy;
                    c_z_reg[k] <= c_z_reg[k-1] - at;
                end
                else
                begin
                    c_x_reg[k] <= c_x_reg[k-1] + dx;
                    c_y_reg[k] <= c_y_reg[k-1] - dy;
                    c_z_reg[k] <= c_z_reg[k-1] + at;
                end
            end
        end
    end

    // undo the angle fold, then axis times sine
    assign last_x     = c_x_reg[NI];
    assign last_y     = c_y_reg[NI];
    assign xn         = c_item_reg[NI].neg ? -last_x : last_x;
    assign yn         = c_item_reg[NI].neg ? -last_y : last_y;
    assign lane_ax[0] = c_item_reg[NI].ax;
    assign lane_ax[1] = c_item_reg[NI].ay;
    assign lane_ax[2] = c_item_reg[NI].az;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (adv)
            m_valid_reg <= c_valid_reg[NI];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_x_reg     <= xn;
            m_len_reg   <= c_item_reg[NI].len8;
            m_degen_reg <= c_item_reg[NI].degen;
        end
    end

    // divider entry carries the shared fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg[0] <= 1'b0;
        else if (adv)
            d_valid_reg[0] <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_x_reg[0]     <= m_x_reg;
            d_len_reg[0]   <= m_len_reg;
            d_degen_reg[0] <= m_degen_reg;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_div_ctl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_valid_reg[k] <= 1'b0;
            else if (adv)
                d_valid_reg[k] <= d_valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_x_reg[k]     <= d_x_reg[k-1];
                d_len_reg[k]   <= d_len_reg[k-1];
                d_degen_reg[k] <= d_degen_reg[k-1];
            end
        end
    end

    // per lane: multiply, magnitude divide, sign and rounding
    for (genvar L = 0; L < NLANE; L++)
    begin : g_lane
        logic signed [PW-1:0] prod_next;
        logic [PW-1:0]        mag;
        logic signed [CW-1:0] qs;

        assign prod_next = lane_ax[L] * yn;
        assign mag       = m_prod_reg[L][PW-1] ? PW'(-m_prod_reg[L]) : PW'(m_prod_reg[L]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m_prod_reg[L]   <= prod_next;
                d_rem_reg[L][0] <= DW'(mag) << 8;
                d_q_reg[L][0]   <= '0;
                d_sgn_reg[L][0] <= m_prod_reg[L][PW-1];
            end
        end

        // restoring division, one quotient bit per stage
        for (genvar k = 1; k <= QW; k++)
        begin : g_div
            localparam int I = QW - k;
            logic [DW-1:0] cand;
            logic          take;

            assign cand = DW'(d_len_reg[k-1]) << I;
            assign take = (d_rem_reg[L][k-1] >= cand);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    d_rem_reg[L][k] <= take ? d_rem_reg[L][k-1] - cand : d_rem_reg[L][k-1];
                    d_q_reg[L][k]   <= d_q_reg[L][k-1] | (QW'(take) << I);
                    d_sgn_reg[L][k] <= d_sgn_reg[L][k-1];
                end
            end
        end

        assign qs = d_sgn_reg[L][QW] ? -$signed({2'b00, d_q_reg[L][QW]})
                                     :  $signed({2'b00, d_q_reg[L][QW]});
        assign lane_q[L] = d_degen_reg[QW] ? '0 : to_q14(qs);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= d_valid_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int n = 0; n < NLANE; n++)
            begin
                o_q_reg[n] <= lane_q[n];
            end
            o_w_reg     <= d_degen_reg[QW] ? Q14_ONE : to_q14(d_x_reg[QW]);
            o_degen_reg <= d_degen_reg[QW];
        end
    end

    assign quat_x          = o_q_reg[0];
    assign quat_y          = o_q_reg[1];
    assign quat_z          = o_q_reg[2];
    assign quat_w          = o_w_reg;
    assign degenerate_axis = o_degen_reg;

    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_empty && degenerate_axis) |->
        (quat_w == Q14_ONE && quat_x == '0 && quat_y == '0 && quat_z == '0))
        else $error("short axis did not give the identity");
    a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n)
        in_pop |=> c_valid_reg[0])
        else $error("request taken from queue but not loaded");

endmodule

[design/axis_angle_to_quaternion_top.sv]
// Top level of the axis-angle to quaternion converter: config register and wiring.
// Depends on aaq_pkg, aaq_front, aaq_fifo and aaq_back.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  input   | push / full            | axis_x, axis_y, axis_z, angle
//  result  | pop / empty            | quat_x, quat_y, quat_z, quat_w, degenerate_axis
//  config  | cfg_valid / cfg_ready  | cfg_data (min_axis_length)
//
// One request per cycle in and out when nothing stalls.
// There are 27 front stages (input, squares, sum, 24 root steps), then the queue, then
// 36 back stages plus one per CORDIC iteration up to ATAN_ENTRIES (load, CORDIC,
// product, divider entry, 32 divide steps, result).
// A full result slot stalls the back end; a full four-entry queue raises full.
// Reset clears all valid bits and the queue; min_axis_length resets to 1.
module axis_angle_to_quaternion_top #(
    parameter int SINCOS_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [15:0] angle,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    output logic               degenerate_axis,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);
    import aaq_pkg::*;

    logic [15:0] min_len_reg;
    logic        front_valid, q_full, q_empty, q_pop;
    aaq_item_t   front_item, q_item;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_len_reg <= 16'd1;
        else if (cfg_valid && cfg_ready)
            min_len_reg <= cfg_data;
    end

    assign full = q_full;

    aaq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (!q_full),
        .push     (push),
        .axis_x   (axis_x),
        .axis_y   (axis_y),
        .axis_z   (axis_z),
        .angle    (angle),
        .min_len  (min_len_reg),
        .out_valid(front_valid),
        .out_item (front_item)
    );

    aaq_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_valid && !q_full),
        .wr_data(front_item),
        .rd_en  (q_pop),
        .rd_data(q_item),
        .empty  (q_empty),
        .full   (q_full)
    );

    aaq_back #(
        .SINCOS_ITERATIONS(SINCOS_ITERATIONS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (!q_empty),
        .in_item        (q_item),
        .in_pop         (q_pop),
        .out_pop        (pop),
        .out_empty      (empty),
        .quat_x         (quat_x),
        .quat_y         (quat_y),
        .quat_z         (quat_z),
        .quat_w         (quat_w),
        .degenerate_axis(degenerate_axis)
    );

endmodule

[tb/tb_axis_angle_to_quaternion_top.sv]
// Testbench for the axis-angle to quaternion converter: directed and random requests,
// a bit-exact predictor and an in-order scoreboard. Depends on aaq_pkg and the RTL top.
module tb_axis_angle_to_quaternion_top;
    timeunit 1ns;
    timeprecision 1ps;
    import aaq_pkg::*;

    typedef struct {
        logic signed [15:0] qx, qy, qz, qw;
        logic               degen;
    } quat_t;

    // scoreboard of expected quaternions, oldest first
    class quat_scoreboard;
        quat_t pending[$];
        int    errors;
        logic [15:0] min_len;

        function new();
            errors  = 0;
            min_len = 16'd1;
        endfunction

        static function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        static function logic [15:0] round_q14(longint v);
            longint r;
            r = (v + 32768) >>> 16;
            if (r > 16384) r = 16384;
            if (r < -16384) r = -16384;
            return r[15:0];
        endfunction

        static function longint floor_sqrt(longint v);
            longint r, b;
            r = 0;
            b = 64'd1 << 48;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // work out the quaternion for one accepted request
        function void note_request(logic signed [15:0] ax, logic signed [15:0] ay,
                                   logic signed [15:0] az, logic signed [15:0] ang);
            quat_t  q;
            longint x, y, z, h, l8, dx, dy, sx, sy, sz;
            bit     flip;
            sx = ax; sy = ay; sz = az;
            l8 = floor_sqrt((sx * sx + sy * sy + sz * sz) << 16);
            if (l8 == 0 || l8 < (longint'(min_len) << 8))
            begin
                q.qx = 0; q.qy = 0; q.qz = 0; q.qw = 16'sd16384; q.degen = 1'b1;
            end
            else
            begin
                h = longint'(ang) * 131072;
                flip = 0;
                if (h > 64'sd1686629713)
                begin
                    h = h - 64'sd3373259426; flip = 1;
                end
                else if (h < -64'sd1686629713)
                begin
                    h = h + 64'sd3373259426; flip = 1;
                end
                x = 64'sd652032874; y = 0; z = h;
                for (int i = 0; i < 16; i++)
                begin
                    dx = floor_shift(y, i);
                    dy = floor_shift(x, i);
                    if (z >= 0)
                    begin
                        x = x - dx; y = y + dy; z = z - longint'(atan_q30(i));
                    end
                    else
                    begin
                        x = x + dx; y = y - dy; z = z + longint'(atan_q30(i));
                    end
                end
                if (flip)
                begin
                    x = -x; y = -y;
                end
                q.qx = round_q14((sx * y * 256) / l8);
                q.qy = round_q14((sy * y * 256) / l8);
                q.qz = round_q14((sz * y * 256) / l8);
                q.qw = round_q14(x);
                q.degen = 1'b0;
            end
            pending.push_back(q);
        endfunction

        // compare one popped result with the oldest expectation
        function void check_result(quat_t got);
            quat_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d d=%0b", $realtime,
                         got.qx, got.qy, got.qz, got.qw, got.degen);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.qx !== e.qx || got.qy !== e.qy || got.qz !== e.qz || got.qw !== e.qw
                || got.degen !== e.degen)
            begin
                $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d d=%0b", $realtime,
                         e.qx, e.qy, e.qz, e.qw, e.degen);
                $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d d=%0b", $realtime,
                         got.qx, got.qy, got.qz, got.qw, got.degen);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, push, full, empty, pop, cfg_valid, cfg_ready, degenerate_axis;
    logic signed [15:0] axis_x, axis_y, axis_z, angle, quat_x, quat_y, quat_z, quat_w;
    logic [15:0] cfg_data;

    quat_scoreboard sb;
    int push_idle_pct, pop_idle_pct, idle_cycles;

    axis_angle_to_quaternion_top u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
        .empty(empty), .pop(pop),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .degenerate_axis(degenerate_axis),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver: random pop, check at the rising edge
    always @(negedge clk)
    begin
        if (rst_n)
            pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    always @(posedge clk)
    begin
        quat_t got;
        if (rst_n && pop && !empty)
        begin
            got.qx = quat_x; got.qy = quat_y; got.qz = quat_z; got.qw = quat_w;
            got.degen = degenerate_axis;
            sb.check_result(got);
        end
    end

    // watchdog on cycles without any push, pop or config handshake
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // send one request, holding it until accepted; push stays high into the next call
    task automatic send_request(logic signed [15:0] ax, logic signed [15:0] ay,
                                logic signed [15:0] az, logic signed [15:0] ang);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 0;
            @(negedge clk);
        end
        push <= 1; axis_x <= ax; axis_y <= ay; axis_z <= az; angle <= ang;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_request(ax, ay, az, ang);
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic write_min_length(logic [15:0] v);
        drain();
        cfg_valid <= 1; cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.min_len = v;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // random axis: mostly full range, sometimes modest scale or tiny
    task automatic random_request();
        logic signed [15:0] ax, ay, az;
        int sel;
        sel = $urandom_range(9);
        ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
        if (sel < 2)
        begin
            ax = $signed(ax) >>> 12; ay = $signed(ay) >>> 12; az = $signed(az) >>> 12;
        end
        else if (sel < 5)
        begin
            ax = $signed(ax) >>> 6; ay = $signed(ay) >>> 6; az = $signed(az) >>> 6;
        end
        send_request(ax, ay, az, 16'($urandom));
    endtask

    initial
    begin
        sb = new();
        rst_n = 0; push = 0; pop = 0; cfg_valid = 0; cfg_data = 0;
        axis_x = 0; axis_y = 0; axis_z = 0; angle = 0;
        push_idle_pct = 0; pop_idle_pct = 0; idle_cycles = 0;
        repeat (3) @(negedge clk);
        rst_n = 1;

        // directed: extremes, zero axis, short axis, angle wrap, overshoot
        send_request(0, 0, 0, 0);
        send_request(1, 0, 0, 16'sd6434);
        send_request(16'sh7FFF, 0, 0, 16'sh7FFF);
        send_request(16'sh8000, 0, 0, 16'sh8000);
        send_request(0, 16'sh7FFF, 0, -16'sd6434);
        send_request(0, 0, 16'sh8000, 16'sd12868);
        send_request(16'sh8000, 16'sh8000, 16'sh8000, 16'sd6433);
        send_request(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sd6435);
        send_request(3, 4, 12, 16'sd12867);
        send_request(1, 1, 1, -16'sd12868);
        send_request(-5, 7, -9, 0);
        send_request(16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
        write_min_length(16'd0);
        send_request(0, 0, 0, 16'sd100);
        send_request(1, 0, 0, 16'sd100);
        write_min_length(16'd100);
        send_request(99, 0, 0, 16'sd500);
        send_request(100, 0, 0, 16'sd500);
        send_request(60, 60, 60, 16'sd500);
        write_min_length(16'hFFFF);
        send_request(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd500);
        send_request(16'sh8000, 16'sh8000, 16'sh8000, 16'sd500);

        // random phases with several minimum lengths and idling mixes
        write_min_length(16'd1);
        push_idle_pct = 8; pop_idle_pct = 51;
        repeat (600) random_request();
        drain();
        write_min_length(16'd20);
        push_idle_pct = 51; pop_idle_pct = 8;
        repeat (600) random_request();
        write_min_length(16'd0);
        push_idle_pct = 0; pop_idle_pct = 0;
        repeat (700) random_request();

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[axis_angle_to_quaternion_top.f]
design/aaq_pkg.sv
design/aaq_front.sv
design/aaq_fifo.sv
design/aaq_back.sv
design/axis_angle_to_quaternion_top.sv
tb/tb_axis_angle_to_quaternion_top.sv
